>>> rtl/mbps_pkg.sv
// Shared types and constants for the masked byte pattern scanner.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package mbps_pkg;

    // Default sizes for the top-level parameters
    localparam int MAX_PATTERN_DEF = 64;
    localparam int OFFSET_BITS_DEF = 32;

    // Fixed field widths
    localparam int LEN_W   = 7;
    localparam int IDX_W   = 6;
    localparam int BYTE_W  = 8;
    localparam int START_W = 32;

    // Item mode codes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_DATA = 1'b1;

    // Reset value of the pattern length register
    localparam logic [LEN_W-1:0] LEN_RESET = 7'd1;

    // Input item
    typedef struct packed {
        logic              mode;
        logic [IDX_W-1:0]  entry_index;
        logic [BYTE_W-1:0] pattern_byte;
        logic              is_wildcard;
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic               match_found;
        logic [START_W-1:0] match_start;
        logic               search_done;
    } t_out_item;

    // One pattern position: wildcard mark and expected byte
    typedef struct packed {
        logic              wild;
        logic [BYTE_W-1:0] value;
    } t_pat_entry;

    // Per-cycle commands broadcast to every cell
    typedef struct packed {
        logic shift;   // a data byte is transferred: move the window one cell on
        logic rotate;  // move the pattern ring one cell on
        logic load;    // write one pattern entry into the selected cell
    } t_cell_ctl;

endpackage

`default_nettype wire

>>> rtl/mbps_cell.sv
// One cell of the scanner row: a window byte, a pattern entry and its compare.
// Depends on mbps_pkg for the entry and command types.
`default_nettype none

module mbps_cell
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int CELL_IDX    = 0,
    localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1,
    localparam int LW = $clog2(MAX_PATTERN + 1)
) (
    input  wire logic              i_clk,
    input  wire t_cell_ctl         i_ctl,
    input  wire logic [IW-1:0]     i_load_cell,
    input  wire t_pat_entry        i_load_entry,
    input  wire logic [LW-1:0]     i_len,
    input  wire logic [BYTE_W-1:0] i_win_in,
    input  wire t_pat_entry        i_pat_in,
    output logic [BYTE_W-1:0]      o_win,
    output t_pat_entry             o_pat,
    output logic                   o_hit
);

    logic [BYTE_W-1:0] r_win;
    t_pat_entry        r_pat;

    // Advance the window byte from the neighbor
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_win <= i_win_in;
        end
    end

    // Rotate the pattern ring, or take a load aimed at this cell
    always_ff @(posedge i_clk) begin
        if (i_ctl.rotate) begin
            r_pat <= i_pat_in;
        end else if (i_ctl.load && (i_load_cell == IW'(CELL_IDX))) begin
            r_pat <= i_load_entry;
        end
    end

    // Compare against the byte that lands here on this transfer; wildcards and cells past the length always hit
    assign o_hit = (i_len <= LW'(CELL_IDX)) | r_pat.wild | (r_pat.value == i_win_in);

    assign o_win = r_win;
    assign o_pat = r_pat;

endmodule

`default_nettype wire

>>> rtl/masked_byte_pattern_scanner.sv
// Masked byte pattern scanner, top level. Uses mbps_pkg and mbps_cell.
// Throughput: one item per clock while o_in_stall is low; a result is registered and shows
// in the cycle after its byte's transfer. After a pattern_length write the input stalls while
// the ring rotates to the new effective length (zero reads as one, capped at MAX_PATTERN).
// Reset (synchronous, active low) clears the region state and sets pattern_length to 1;
// pattern entries are undefined until loaded.
`default_nettype none

module masked_byte_pattern_scanner
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // input channel
    input  wire logic             i_in_valid,
    input  wire t_in_item         i_in_item,
    output logic                  o_in_stall,
    // result channel
    output logic                  o_out_valid,
    output t_out_item             o_out_item,
    input  wire logic             i_out_stall,
    // pattern_length register write
    input  wire logic             i_cfg_valid,
    input  wire logic [LEN_W-1:0] i_cfg_data,
    output logic                  o_cfg_ready
);

    localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int XW = ((IW > IDX_W) ? IW : IDX_W) + 1;
    localparam int OB = OFFSET_BITS;

    logic [LEN_W-1:0]  r_len;
    logic [IW-1:0]     r_align, n_align;
    logic [OB-1:0]     r_seen, n_seen;
    logic              r_found, n_found;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    logic [8:0]        len_wide;
    logic [LW-1:0]     eff_len;
    logic [IW-1:0]     target;
    logic              busy;
    logic              in_acc, data_acc, load_acc, idx_ok;
    logic [XW-1:0]     ext_align, ext_idx, diff;
    logic [IW-1:0]     load_cell;
    logic [OB-1:0]     n_cnt;
    logic [OB+START_W-1:0] start_wide;
    logic [START_W-1:0] start32;
    logic              match, has_result;
    t_cell_ctl         ctl;
    t_pat_entry        load_entry;

    logic [BYTE_W-1:0]      win [MAX_PATTERN];
    t_pat_entry             pat [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] hit;

    // Effective length: zero reads as one, saturate at the row length
    always_comb begin
        len_wide = {2'b00, r_len};
        if (r_len == '0) begin
            len_wide = 9'd1;
        end else if (len_wide > 9'(MAX_PATTERN)) begin
            len_wide = 9'(MAX_PATTERN);
        end
    end
    assign eff_len = LW'(len_wide);
    assign target  = IW'(eff_len - LW'(1));
    assign busy    = (r_align != target);

    // Handshakes
    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = busy | (r_out_valid & i_out_stall);
    assign in_acc      = i_in_valid & ~o_in_stall;
    assign idx_ok      = (9'(i_in_item.entry_index) < 9'(MAX_PATTERN));
    assign data_acc    = in_acc & (i_in_item.mode == MODE_DATA);
    assign load_acc    = in_acc & (i_in_item.mode == MODE_LOAD) & idx_ok;

    // Cell holding pattern entry idx: (align - idx) mod MAX_PATTERN
    assign ext_align = XW'(r_align);
    assign ext_idx   = XW'(i_in_item.entry_index);
    assign diff      = (ext_align >= ext_idx) ? (ext_align - ext_idx)
                                              : (ext_align + XW'(MAX_PATTERN) - ext_idx);
    assign load_cell = IW'(diff);

    assign load_entry.wild  = i_in_item.is_wildcard;
    assign load_entry.value = i_in_item.pattern_byte;

    assign ctl.shift  = data_acc;
    assign ctl.rotate = busy;
    assign ctl.load   = load_acc;

    // Row of cells: window moves up from cell 0, pattern ring moves up and wraps
    for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
        logic [BYTE_W-1:0] win_in;
        t_pat_entry        pat_in;
        if (j == 0) begin : g_head
            assign win_in = i_in_item.data_byte;
            assign pat_in = pat[MAX_PATTERN-1];
        end else begin : g_body
            assign win_in = win[j-1];
            assign pat_in = pat[j-1];
        end
        mbps_cell #(
            .MAX_PATTERN (MAX_PATTERN),
            .CELL_IDX    (j)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_load_cell  (load_cell),
            .i_load_entry (load_entry),
            .i_len        (eff_len),
            .i_win_in     (win_in),
            .i_pat_in     (pat_in),
            .o_win        (win[j]),
            .o_pat        (pat[j]),
            .o_hit        (hit[j])
        );
    end

    // Offset count with saturation, match test and start offset
    assign n_cnt      = (r_seen == '1) ? r_seen : (r_seen + OB'(1));
    assign start_wide = {{START_W{1'b0}}, n_cnt - OB'(eff_len)};
    assign start32    = start_wide[START_W-1:0];
    assign match      = ~r_found & (n_cnt >= OB'(eff_len)) & (&hit);
    assign has_result = match | (~r_found & i_in_item.last_byte);

    // Region state and ring alignment
    always_comb begin
        n_seen  = r_seen;
        n_found = r_found;
        n_align = r_align;
        if (busy) begin
            n_align = (r_align == IW'(MAX_PATTERN - 1)) ? '0 : (r_align + IW'(1));
        end
        if (data_acc) begin
            if (i_in_item.last_byte) begin
                n_seen  = '0;
                n_found = 1'b0;
            end else begin
                n_seen = n_cnt;
                if (match) begin
                    n_found = 1'b1;
                end
            end
        end
    end

    // Output register: load a result, drop it once transferred
    always_comb begin
        n_out_valid = r_out_valid & i_out_stall;
        n_out       = r_out;
        if (data_acc && has_result) begin
            n_out_valid       = 1'b1;
            n_out.match_found = match;
            n_out.match_start = match ? start32 : '0;
            n_out.search_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= LEN_RESET;
            r_align     <= '0;
            r_seen      <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_len <= i_cfg_data;
            end
            r_align     <= n_align;
            r_seen      <= n_seen;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold result payload
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // A new result never overwrites one still waiting downstream
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (data_acc && has_result) |-> (!r_out_valid || !i_out_stall))
        else $error("result loaded while output slot is blocked");

    // A not-found result carries a zero offset and ends the search
    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.match_found) |-> (r_out.match_start == '0 && r_out.search_done))
        else $error("not-found result with nonzero offset or open search");

    // A match inside a region sets the found flag, which suppresses later results until the region ends
    a_found_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (data_acc && match && !i_in_item.last_byte) |=> r_found)
        else $error("match did not set the found flag");

    // While realigning, the ring advances every cycle
    a_ring_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && !(i_cfg_valid && o_cfg_ready)) |=> (r_align != $past(r_align)
            || MAX_PATTERN == 1))
        else $error("pattern ring stalled during realignment");

endmodule

`default_nettype wire

>>> verif/tb_masked_byte_pattern_scanner.sv
`timescale 1ns / 1ps
// Self-checking testbench for masked_byte_pattern_scanner: a directed table,
// then random pattern loads and byte regions. Depends on mbps_pkg and the RTL.

module tb_masked_byte_pattern_scanner;
    import mbps_pkg::*;

    localparam int MAX_PAT = MAX_PATTERN_DEF;
    localparam int ITEMS   = 750;
    localparam int LIMIT   = 200000;

    typedef enum logic [1:0] {ROW_MODEL, ROW_QUIET, ROW_FIXED, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        t_in_item          item;
        t_out_item         res;
        logic [LEN_W-1:0]  len;
    } t_plan_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    t_in_item         i_in_item = '0;
    logic             o_in_stall;
    logic             o_out_valid;
    t_out_item        o_out_item;
    logic             i_out_stall = 1'b0;
    logic             i_cfg_valid = 1'b0;
    logic [LEN_W-1:0] i_cfg_data = '0;
    logic             o_cfg_ready;

    // Sideband that travels with the item on the input channel
    t_row_kind row_kind = ROW_MODEL;
    t_out_item row_res = '0;

    // Scanner shadow state
    t_pat_entry       pat_tab [MAX_PAT];
    logic [7:0]       win [MAX_PAT];
    logic [31:0]      seen = '0;
    bit               found = 1'b0;
    logic [LEN_W-1:0] plen = LEN_RESET;

    // Expected reports, oldest first
    t_out_item due_reports [$];

    // Driver-side view of the loaded pattern
    t_pat_entry       sent_tab [MAX_PAT];
    bit [MAX_PAT-1:0] sent_mask = '0;
    int unsigned      cur_len = 1;

    int unsigned errors = 0;
    int unsigned sent = 0;
    int unsigned cycles = 0;
    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned hold_left = 0;

    t_plan_row directed [22];

    masked_byte_pattern_scanner u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready)
    );

    always #5 i_clk = ~i_clk;

    // Advance the shadow scanner by one item; return 1 when it reports
    function automatic bit advance_scan(input t_in_item it, output t_out_item res);
        int unsigned n;
        bit hit;
        res = '0;
        if (it.mode == MODE_LOAD) begin
            pat_tab[it.entry_index] = '{wild: it.is_wildcard, value: it.pattern_byte};
            return 1'b0;
        end
        for (int i = MAX_PAT - 1; i > 0; i--) win[i] = win[i-1];
        win[0] = it.data_byte;
        if (seen != '1) seen = seen + 1;
        n = (plen == 0) ? 1 : ((plen > MAX_PAT) ? MAX_PAT : plen);
        hit = !found && (seen >= n);
        for (int p = 0; p < n; p++) begin
            if (!pat_tab[p].wild && pat_tab[p].value != win[n-1-p]) hit = 1'b0;
        end
        if (hit) begin
            found = 1'b1;
            res = '{match_found: 1'b1, match_start: seen - n, search_done: 1'b1};
        end else if (!found && it.last_byte) begin
            res = '{match_found: 1'b0, match_start: '0, search_done: 1'b1};
        end
        advance_scan = hit || (!found && it.last_byte) || (hit && it.last_byte);
        if (it.last_byte) begin
            foreach (win[i]) win[i] = '0;
            seen = '0;
            found = 1'b0;
        end
    endfunction

    function automatic void flag(input string what, input t_out_item w, input t_out_item g);
        errors++;
        if (errors <= 10)
            $display("%s: expected found=%0b start=%0d done=%0b, got found=%0b start=%0d done=%0b",
                     what, w.match_found, w.match_start, w.search_done,
                     g.match_found, g.match_start, g.search_done);
    endfunction

    function automatic t_out_item outcome(input bit f, input int unsigned s, input bit d);
        return '{match_found: f, match_start: s, search_done: d};
    endfunction

    function automatic t_plan_row row_load(input int unsigned idx, input logic [7:0] val,
                                           input bit wild);
        t_plan_row r;
        r = '0;
        r.kind = ROW_QUIET;
        r.item.mode = MODE_LOAD;
        r.item.entry_index = IDX_W'(idx);
        r.item.pattern_byte = val;
        r.item.is_wildcard = wild;
        return r;
    endfunction

    function automatic t_plan_row row_data(input logic [7:0] val, input bit last,
                                           input t_row_kind kind, input t_out_item res = '0);
        t_plan_row r;
        r = '0;
        r.kind = kind;
        r.item.mode = MODE_DATA;
        r.item.data_byte = val;
        r.item.last_byte = last;
        r.res = res;
        return r;
    endfunction

    function automatic t_plan_row row_cfg(input logic [LEN_W-1:0] len);
        t_plan_row r;
        r = '0;
        r.kind = ROW_CFG;
        r.len = len;
        return r;
    endfunction

    function automatic t_in_item any_item();
        logic [$bits(t_in_item)-1:0] raw;
        raw = $bits(t_in_item)'($urandom);
        return raw;
    endfunction

    // Check every result transfer and record every input and config transfer
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item guess;
        bit made;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) plen = i_cfg_data;
            if (i_in_valid && !o_in_stall) begin
                made = advance_scan(i_in_item, guess);
                if (row_kind == ROW_FIXED) due_reports.push_back(row_res);
                else if (row_kind == ROW_MODEL && made) due_reports.push_back(guess);
            end
            if (o_out_valid && !i_out_stall) begin
                if (due_reports.size() == 0) begin
                    flag("unexpected result", '0, o_out_item);
                end else begin
                    want = due_reports.pop_front();
                    if (want.match_found !== o_out_item.match_found ||
                        want.match_start !== o_out_item.match_start ||
                        want.search_done !== o_out_item.search_done)
                        flag("mismatch", want, o_out_item);
                end
            end
        end
    end

    // Stall the result channel in random bursts
    always @(posedge i_clk) begin
        if (!i_rst_n || stall_pct == 0) begin
            i_out_stall <= 1'b0;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            i_out_stall <= 1'b1;
            hold_left <= $urandom_range(0, 6);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Present one item and hold it until the transfer
    task automatic send(input t_in_item it, input t_row_kind kind, input t_out_item res);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        if (it.mode == MODE_LOAD) begin
            sent_tab[it.entry_index] = '{wild: it.is_wildcard, value: it.pattern_byte};
            sent_mask[it.entry_index] = 1'b1;
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        row_kind <= kind;
        row_res <= res;
        do @(posedge i_clk); while (o_in_stall);
        sent++;
    endtask

    // Hold off the input until every expected report has arrived
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (due_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_len(input logic [LEN_W-1:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_len = (v == 0) ? 1 : ((v > MAX_PAT) ? MAX_PAT : v);
    endtask

    task automatic load_entry(input int unsigned idx, input bit wild);
        t_in_item it;
        it = any_item();
        it.mode = MODE_LOAD;
        it.entry_index = IDX_W'(idx);
        it.is_wildcard = wild;
        send(it, ROW_MODEL, '0);
    endtask

    // Stream one region: mostly a planted pattern, some spoiled, some pure noise
    task automatic scan_region(input int unsigned fill);
        logic [7:0] region [$];
        int unsigned pick, at, spot;
        t_in_item it;
        pick = $urandom_range(0, 99);
        at = $urandom_range(0, fill);
        repeat (at) region.push_back(8'($urandom_range(0, 255)));
        for (int p = 0; p < cur_len; p++) begin
            if (pick >= 75 || sent_tab[p].wild) region.push_back(8'($urandom_range(0, 255)));
            else region.push_back(sent_tab[p].value);
        end
        if (pick >= 60 && pick < 75) begin
            spot = at + $urandom_range(0, cur_len - 1);
            region[spot] = region[spot] ^ 8'($urandom_range(1, 255));
        end
        repeat ($urandom_range(0, fill)) region.push_back(8'($urandom_range(0, 255)));
        foreach (region[k]) begin
            if ($urandom_range(0, 49) == 0)
                load_entry($urandom_range(0, MAX_PAT - 1), $urandom_range(0, 4) == 0);
            it = any_item();
            it.mode = MODE_DATA;
            it.data_byte = region[k];
            it.last_byte = (k == region.size() - 1);
            send(it, ROW_MODEL, '0);
        end
    endtask

    // Pick a length and make sure every position in use is loaded
    task automatic new_setting();
        logic [LEN_W-1:0] v;
        bit refresh;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = LEN_W'(127);
            2: v = LEN_W'(MAX_PAT);
            3: v = LEN_W'($urandom_range(MAX_PAT + 1, 126));
            4: v = LEN_W'($urandom_range(9, MAX_PAT - 1));
            default: v = LEN_W'($urandom_range(1, 8));
        endcase
        write_len(v);
        refresh = ($urandom_range(0, 1) == 1);
        for (int p = 0; p < cur_len; p++) begin
            if (!sent_mask[p] || (refresh && cur_len <= 8))
                load_entry(p, $urandom_range(0, 4) == 0);
        end
    endtask

    initial begin
        directed = '{
            row_load(0, 8'hA5, 1'b0),
            row_data(8'h00, 1'b0, ROW_QUIET),
            row_data(8'hA5, 1'b0, ROW_FIXED, outcome(1'b1, 1, 1'b1)),
            row_data(8'hA5, 1'b0, ROW_QUIET),
            row_data(8'hFF, 1'b1, ROW_QUIET),
            row_data(8'hFF, 1'b1, ROW_FIXED, outcome(1'b0, 0, 1'b1)),
            row_data(8'hA5, 1'b1, ROW_FIXED, outcome(1'b1, 0, 1'b1)),
            row_load(MAX_PAT - 1, 8'hFF, 1'b1),
            row_load(0, 8'h00, 1'b1),
            row_data(8'h00, 1'b0, ROW_FIXED, outcome(1'b1, 0, 1'b1)),
            row_data(8'h37, 1'b1, ROW_QUIET),
            row_cfg(LEN_W'(0)),
            row_load(0, 8'h00, 1'b0),
            row_data(8'hFF, 1'b0, ROW_QUIET),
            row_data(8'h00, 1'b1, ROW_FIXED, outcome(1'b1, 1, 1'b1)),
            row_cfg(LEN_W'(2)),
            row_load(1, 8'h00, 1'b0),
            row_data(8'h00, 1'b0, ROW_QUIET),
            row_data(8'h00, 1'b0, ROW_FIXED, outcome(1'b1, 0, 1'b1)),
            row_data(8'h5A, 1'b1, ROW_QUIET),
            row_data(8'h12, 1'b0, ROW_MODEL),
            row_data(8'h00, 1'b1, ROW_MODEL)
        };
        foreach (pat_tab[i]) pat_tab[i] = '0;
        foreach (win[i]) win[i] = '0;
        foreach (sent_tab[i]) sent_tab[i] = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        idle_pct = 20;
        stall_pct = 20;
        foreach (directed[r]) begin
            if (directed[r].kind == ROW_CFG) write_len(directed[r].len);
            else send(directed[r].item, directed[r].kind, directed[r].res);
        end

        // Random phases with varying idle rates on both sides; leave room for the close
        while (sent < ITEMS - 150) begin
            new_setting();
            case ($urandom_range(0, 2))
                0: idle_pct = 0;
                1: idle_pct = 8;
                default: idle_pct = 25;
            endcase
            case ($urandom_range(0, 2))
                0: stall_pct = 0;
                1: stall_pct = 8;
                default: stall_pct = 25;
            endcase
            if (cur_len > 8) begin
                repeat (2) scan_region($urandom_range(0, 8));
            end else begin
                repeat ($urandom_range(3, 8)) scan_region($urandom_range(0, 12));
            end
        end

        // Closing stretch at full rate
        idle_pct = 0;
        stall_pct = 0;
        write_len(LEN_W'($urandom_range(1, 6)));
        for (int p = 0; p < cur_len; p++) load_entry(p, $urandom_range(0, 4) == 0);
        repeat (8) scan_region(6);

        drain();
        repeat (8) @(posedge i_clk);
        if (errors == 0 && due_reports.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
